// ===== src/prq_pkg.sv =====
package prq_pkg;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_SET_BIT  = 3'd1,
    REQ_CLR_BIT  = 3'd2,
    REQ_SCHEDULE = 3'd3,
    REQ_YIELD    = 3'd4,
    REQ_LOCK     = 3'd5,
    REQ_UNLOCK   = 3'd6,
    REQ_NONE     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_READY = 2'd1,
    ST_QUEUED   = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_READ,
    EX_WRITE,
    EX_OUT
  } ex_state_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] task_id;
    logic [4:0] priority_req;
    logic       in_interrupt;
  } req_in_t;

  typedef struct packed {
    logic [4:0]  current_task;
    logic        current_valid;
    logic        switched;
    logic        switch_deferred;
    logic [31:0] ready_bits;
    logic [1:0]  status;
  } resp_out_t;

  localparam int LockMax = 255;

endpackage

// ===== src/priority_ready_queue_scheduler_unit.sv =====
// The back end takes one request from the front queue, reads, then writes, link
// tables, and takes no new request until out_ready has taken its response.
// A two-entry queue in front accepts requests while the back end works.
// Reset (rst, synchronous) clears the ready bitmap, queue and task flags and lock count.
// Link and head tables hold no reset value and are written before they are read.
module priority_ready_queue_scheduler_unit #(
  parameter int NUM_PRIORITIES = 32,
  parameter int MAX_TASKS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  prq_pkg::req_in_t   in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output prq_pkg::resp_out_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import prq_pkg::*;

  req_in_t q_data;
  logic    q_valid;
  logic    q_ready;

  prq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready)
  );

  prq_back #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .MAX_TASKS      (MAX_TASKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// ===== src/prq_front.sv =====
module prq_front (
  input  logic            clk,
  input  logic            rst,
  input  prq_pkg::req_in_t in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output prq_pkg::req_in_t q_data,
  output logic            q_valid,
  input  logic            q_ready
);
  import prq_pkg::*;

  req_in_t    buf_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = buf_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_data[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && q_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({in_valid && in_ready, q_valid && q_ready})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/prq_back.sv =====
module prq_back #(
  parameter int NUM_PRIORITIES = 32,
  parameter int MAX_TASKS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  prq_pkg::req_in_t  q_data,
  input  logic              q_valid,
  output logic              q_ready,
  output prq_pkg::resp_out_t out_data,
  output logic              out_valid,
  input  logic              out_ready
);
  import prq_pkg::*;

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

  logic [TW-1:0] mem_head [NUM_PRIORITIES];
  logic [TW-1:0] mem_tail [NUM_PRIORITIES];
  logic [TW-1:0] mem_next [MAX_TASKS];
  logic [TW-1:0] mem_prev [MAX_TASKS];

  logic [NUM_PRIORITIES-1:0] queue_nonempty;
  logic [MAX_TASKS-1:0]      task_queued;
  logic [31:0]               ready_mask;
  logic [TW-1:0]             running_task;
  logic [PW-1:0]             run_prio;
  logic                      running_valid;
  logic                      yield_pending;
  logic [7:0]                lock_count;
  logic                      switch_pending;

  ex_state_t state;
  ex_state_t state_next;
  req_in_t   cur;
  status_t   status;
  logic      sel;

  // Operands latched in the read cycle.
  logic          do_add;
  logic          do_rot;
  logic          do_pick;
  logic [PW-1:0] op_p;
  logic [TW-1:0] op_id;
  logic          rd_ne;
  logic [TW-1:0] rd_head;
  logic [TW-1:0] rd_tail;
  logic [TW-1:0] rd_next;
  logic [TW-1:0] rd_prev;
  logic [TW-1:0] pick_head;
  logic [PW-1:0] pick_p;

  logic          lsb_found;
  logic [PW-1:0] lsb_idx;

  always_comb begin
    lsb_found = 1'b0;
    lsb_idx   = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (ready_mask[i]) begin
        lsb_found = 1'b1;
        lsb_idx   = PW'(i);
      end
    end
  end

  logic [TW-1:0] id_w;
  logic [4:0]    p_in;
  logic          id_ok;
  logic          p_ok;
  logic          perform;
  logic          rot_ok;

  assign id_w    = TW'(cur.task_id);
  assign p_in    = cur.priority_req;
  assign id_ok   = 32'(cur.task_id) < 32'(MAX_TASKS);
  assign p_ok    = 32'(cur.priority_req) < 32'(NUM_PRIORITIES);
  assign perform = !cur.in_interrupt && (lock_count == 8'd0);
  assign rot_ok  = running_valid && task_queued[running_task] && queue_nonempty[run_prio];

  logic    dec_add;
  logic    dec_rot;
  logic    dec_pick;
  logic    dec_sel;
  status_t dec_status;

  always_comb begin
    dec_add    = 1'b0;
    dec_rot    = 1'b0;
    dec_pick   = 1'b0;
    dec_sel    = 1'b0;
    dec_status = ST_OK;
    unique case (req_t'(cur.req_type))
      REQ_ADD: begin
        if (id_ok && p_ok) begin
          if (task_queued[id_w]) begin
            dec_status = ST_QUEUED;
          end else begin
            dec_add = 1'b1;
          end
        end
      end
      REQ_SCHEDULE, REQ_YIELD: begin
        if (perform) begin
          if ((yield_pending || req_t'(cur.req_type) == REQ_YIELD) && rot_ok) begin
            dec_rot = 1'b1;
            dec_sel = 1'b1;
          end else if (!lsb_found || !queue_nonempty[lsb_idx]) begin
            dec_status = ST_NO_READY;
          end else begin
            dec_pick = 1'b1;
            dec_sel  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE:  if (q_valid) state_next = EX_READ;
      EX_READ:  state_next = EX_WRITE;
      EX_WRITE: state_next = EX_OUT;
      EX_OUT:   if (out_ready) state_next = EX_IDLE;
      default:  state_next = EX_IDLE;
    endcase
  end

  assign q_ready   = (state == EX_IDLE);
  assign out_valid = (state == EX_OUT);

  always_comb begin
    out_data.current_task    = running_valid ? 5'(running_task) : 5'd0;
    out_data.current_valid   = running_valid;
    out_data.switched        = sel;
    out_data.switch_deferred = switch_pending;
    out_data.ready_bits      = ready_mask;
    out_data.status          = status;
  end

  logic [TW-1:0] rot_new_head;
  assign rot_new_head = (rd_head == op_id) ? rd_next : rd_head;

  always_ff @(posedge clk) begin
    if (state == EX_IDLE && q_valid) begin
      cur <= q_data;
    end
    if (state == EX_READ) begin
      op_id     <= (req_t'(cur.req_type) == REQ_ADD) ? id_w : running_task;
      op_p      <= (req_t'(cur.req_type) == REQ_ADD) ? PW'(p_in) : run_prio;
      rd_ne     <= (req_t'(cur.req_type) == REQ_ADD) ? queue_nonempty[PW'(p_in)]
                                                    : queue_nonempty[run_prio];
      rd_head   <= mem_head[(req_t'(cur.req_type) == REQ_ADD) ? PW'(p_in) : run_prio];
      rd_tail   <= mem_tail[(req_t'(cur.req_type) == REQ_ADD) ? PW'(p_in) : run_prio];
      rd_next   <= mem_next[running_task];
      rd_prev   <= mem_prev[running_task];
      pick_head <= mem_head[lsb_idx];
      pick_p    <= lsb_idx;
    end
    if (state == EX_WRITE) begin
      if (do_add) begin
        if (rd_ne) begin
          mem_next[rd_tail] <= op_id;
          mem_prev[op_id]   <= rd_tail;
        end else begin
          mem_head[op_p] <= op_id;
        end
        mem_tail[op_p] <= op_id;
      end
      if (do_rot && rd_tail != op_id) begin
        if (rd_head == op_id) begin
          mem_head[op_p] <= rd_next;
        end else begin
          mem_next[rd_prev] <= rd_next;
          mem_prev[rd_next] <= rd_prev;
        end
        mem_next[rd_tail] <= op_id;
        mem_prev[op_id]   <= rd_tail;
        mem_tail[op_p]    <= op_id;
      end
    end

    if (rst) begin
      state          <= EX_IDLE;
      queue_nonempty <= '0;
      task_queued    <= '0;
      ready_mask     <= '0;
      running_task   <= '0;
      run_prio       <= '0;
      running_valid  <= 1'b0;
      yield_pending  <= 1'b0;
      lock_count     <= 8'd0;
      switch_pending <= 1'b0;
      do_add         <= 1'b0;
      do_rot         <= 1'b0;
      do_pick        <= 1'b0;
      status         <= ST_OK;
      sel            <= 1'b0;
    end else begin
      state <= state_next;
      if (state == EX_WRITE) begin
        if (do_rot) begin
          running_task <= (rd_tail != op_id) ? rot_new_head : rd_head;
        end else if (do_pick) begin
          running_task <= pick_head;
          run_prio     <= pick_p;
        end
      end
      if (state == EX_READ) begin
        do_add  <= dec_add;
        do_rot  <= dec_rot;
        do_pick <= dec_pick;
        status  <= dec_status;
        sel     <= dec_sel;
        unique case (req_t'(cur.req_type))
          REQ_ADD: begin
            if (dec_add) begin
              task_queued[id_w] <= 1'b1;
              queue_nonempty[PW'(p_in)] <= 1'b1;
              ready_mask[PW'(p_in)] <= 1'b1;
            end
          end
          REQ_SET_BIT: if (p_ok) ready_mask[PW'(p_in)] <= 1'b1;
          REQ_CLR_BIT: if (p_ok) ready_mask[PW'(p_in)] <= 1'b0;
          REQ_SCHEDULE, REQ_YIELD: begin
            if (!perform) begin
              switch_pending <= 1'b1;
              if (req_t'(cur.req_type) == REQ_YIELD) yield_pending <= 1'b1;
            end else begin
              switch_pending <= 1'b0;
              yield_pending  <= 1'b0;
              if (dec_pick) running_valid <= 1'b1;
            end
          end
          REQ_LOCK:   if (lock_count != 8'(LockMax)) lock_count <= lock_count + 8'd1;
          REQ_UNLOCK: if (lock_count != 8'd0) lock_count <= lock_count - 8'd1;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import prq_pkg::*;

  localparam int NPRIO = 32;
  localparam int NTASK = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_in_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  resp_out_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;

  priority_ready_queue_scheduler_unit dut (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_data(out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  always #5 clk = ~clk;

  // Scheduler shadow state.
  logic [31:0] sh_ready;
  logic [4:0] sh_head [NPRIO];
  logic [4:0] sh_tail [NPRIO];
  logic sh_nonempty [NPRIO];
  logic [4:0] sh_next [NTASK];
  logic [4:0] sh_prev [NTASK];
  logic [4:0] sh_prio [NTASK];
  logic sh_queued [NTASK];
  logic [4:0] sh_run;
  logic sh_run_valid;
  logic sh_yield;
  logic [7:0] sh_lock;
  logic sh_pending;

  req_in_t pending_reqs[$];
  resp_out_t expected_resps[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void sched_reset();
    sh_ready = '0;
    for (int i = 0; i < NPRIO; i++) sh_nonempty[i] = 1'b0;
    for (int i = 0; i < NTASK; i++) sh_queued[i] = 1'b0;
    sh_run = '0;
    sh_run_valid = 1'b0;
    sh_yield = 1'b0;
    sh_lock = '0;
    sh_pending = 1'b0;
  endfunction

  function automatic void queue_append(logic [4:0] id, logic [4:0] p);
    if (sh_nonempty[p]) begin
      sh_next[sh_tail[p]] = id;
      sh_prev[id] = sh_tail[p];
    end else begin
      sh_head[p] = id;
      sh_nonempty[p] = 1'b1;
    end
    sh_tail[p] = id;
  endfunction

  function automatic void queue_rotate(logic [4:0] id, logic [4:0] p);
    logic [4:0] n;
    logic [4:0] pr;
    if (sh_tail[p] == id) return;
    n = sh_next[id];
    if (sh_head[p] == id) begin
      sh_head[p] = n;
    end else begin
      pr = sh_prev[id];
      sh_next[pr] = n;
      sh_prev[n] = pr;
    end
    queue_append(id, p);
  endfunction

  function automatic status_t run_switch(output logic sel);
    logic [4:0] p;
    int i;
    sel = 1'b0;
    sh_pending = 1'b0;
    if (sh_yield) begin
      sh_yield = 1'b0;
      if (sh_run_valid && sh_queued[sh_run]) begin
        p = sh_prio[sh_run];
        if (sh_nonempty[p]) begin
          queue_rotate(sh_run, p);
          sh_run = sh_head[p];
          sel = 1'b1;
          return ST_OK;
        end
      end
    end
    for (i = 0; i < NPRIO; i++) if (sh_ready[i]) break;
    if (i >= NPRIO) return ST_NO_READY;
    if (!sh_nonempty[i]) return ST_NO_READY;
    sh_run = sh_head[i];
    sh_run_valid = 1'b1;
    sel = 1'b1;
    return ST_OK;
  endfunction

  function automatic resp_out_t sched_step(req_in_t rq);
    resp_out_t r;
    status_t st;
    logic sel;
    st = ST_OK;
    sel = 1'b0;
    case (req_t'(rq.req_type))
      REQ_ADD: begin
        if (sh_queued[rq.task_id]) begin
          st = ST_QUEUED;
        end else begin
          queue_append(rq.task_id, rq.priority_req);
          sh_prio[rq.task_id] = rq.priority_req;
          sh_queued[rq.task_id] = 1'b1;
          sh_ready[rq.priority_req] = 1'b1;
        end
      end
      REQ_SET_BIT: sh_ready[rq.priority_req] = 1'b1;
      REQ_CLR_BIT: sh_ready[rq.priority_req] = 1'b0;
      REQ_SCHEDULE, REQ_YIELD: begin
        if (req_t'(rq.req_type) == REQ_YIELD) sh_yield = 1'b1;
        if (rq.in_interrupt || sh_lock != 0) sh_pending = 1'b1;
        else st = run_switch(sel);
      end
      REQ_LOCK: if (sh_lock != 8'd255) sh_lock = sh_lock + 8'd1;
      REQ_UNLOCK: if (sh_lock != 0) sh_lock = sh_lock - 8'd1;
      default: ;
    endcase
    r.current_task = sh_run_valid ? sh_run : 5'd0;
    r.current_valid = sh_run_valid;
    r.switched = sel;
    r.switch_deferred = sh_pending;
    r.ready_bits = sh_ready;
    r.status = st;
    return r;
  endfunction

  function automatic req_in_t make_req(req_t op, int id, int p, bit intr);
    req_in_t r;
    r.req_type = op;
    r.task_id = id[4:0];
    r.priority_req = p[4:0];
    r.in_interrupt = intr;
    return r;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      in_data <= pending_reqs.pop_front();
      in_valid <= 1'b1;
      in_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // The prediction is made when the request transaction is accepted.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_resps.push_back(sched_step(in_data));
  end

  // Monitor.
  always @(posedge clk) begin
    resp_out_t e;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", out_data);
        end else begin
          e = expected_resps.pop_front();
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected task=%0d v=%0d sw=%0d def=%0d rdy=%h st=%0d",
                e.current_task, e.current_valid, e.switched, e.switch_deferred,
                e.ready_bits, e.status);
              $display("          got task=%0d v=%0d sw=%0d def=%0d rdy=%h st=%0d",
                out_data.current_task, out_data.current_valid, out_data.switched,
                out_data.switch_deferred, out_data.ready_bits, out_data.status);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int n;
    int op;
    int id;
    int p;
    int q;
    sched_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SET_BIT, 0, 31, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_ADD, 31, 31, 1));
    pending_reqs.push_back(make_req(REQ_ADD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_ADD, 5, 0, 0));
    pending_reqs.push_back(make_req(REQ_ADD, 5, 3, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 1));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOCK, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_UNLOCK, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_UNLOCK, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_CLR_BIT, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_CLR_BIT, 0, 31, 0));
    pending_reqs.push_back(make_req(REQ_SET_BIT, 0, 7, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_NONE, 31, 31, 1));
    for (int i = 0; i < 260; i++) pending_reqs.push_back(make_req(REQ_LOCK, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));
    for (int i = 0; i < 258; i++) pending_reqs.push_back(make_req(REQ_UNLOCK, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SCHEDULE, 0, 0, 0));

    // Random part; mostly adds and scheduling with occasional interrupts and locks.
    n = 0;
    while (n < 906) begin
      q = $urandom_range(0, 99);
      id = $urandom_range(0, 31);
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
      if (q < 25) op = REQ_ADD;
      else if (q < 35) op = REQ_SET_BIT;
      else if (q < 43) op = REQ_CLR_BIT;
      else if (q < 63) op = REQ_SCHEDULE;
      else if (q < 85) op = REQ_YIELD;
      else if (q < 92) op = REQ_LOCK;
      else if (q < 99) op = REQ_UNLOCK;
      else op = REQ_NONE;
      pending_reqs.push_back(make_req(req_t'(op), id, p, $urandom_range(0, 5) == 0));
      n++;
    end
    pending_reqs.push_back(make_req(REQ_UNLOCK, 0, 0, 0));

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_resps.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/prq_pkg.sv
src/prq_front.sv
src/prq_back.sv
src/priority_ready_queue_scheduler_unit.sv
sim/tb_top.sv
